// ===== hw/rtl/rgb_layer_blend_unit_top_macros.svh =====
// assertion macros for the layer blend unit
// each expects clk and rst_n in the scope where it is used
`ifndef RGB_LAYER_BLEND_UNIT_TOP_MACROS_SVH
`define RGB_LAYER_BLEND_UNIT_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define RLBU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RLBU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RLBU_ASSERT_SAME(lbl, ante, cons, msg)
`define RLBU_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/rlbu_pkg.sv =====
`timescale 1ns / 1ps

package rlbu_pkg;

  localparam int CHAN_W    = 8;
  localparam int NUM_LANES = 3;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 8;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_BLEND_MODE   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SCALE_FACTOR = 2'd1;

  // blend mode codes
  localparam logic [2:0] MODE_MULTIPLY   = 3'd0;
  localparam logic [2:0] MODE_SCREEN     = 3'd1;
  localparam logic [2:0] MODE_SUBTRACT   = 3'd2;
  localparam logic [2:0] MODE_OVERLAY    = 3'd3;
  localparam logic [2:0] MODE_SCALE_RED  = 3'd4;
  localparam logic [2:0] MODE_SCALE_BLUE = 3'd5;

  // lane positions
  localparam logic [1:0] LANE_RED   = 2'd0;
  localparam logic [1:0] LANE_GREEN = 2'd1;
  localparam logic [1:0] LANE_BLUE  = 2'd2;

  // reciprocal of 255: floor(x / 255) == (x * DIV255_MUL) >> DIV255_SHIFT
  // holds for every x below 132626, enough for the doubled overlay product
  localparam int DIV255_MUL   = 131587;
  localparam int DIV255_SHIFT = 25;
  localparam int ROUND_BIAS   = 127;

  // per-lane operation
  typedef enum logic [2:0] {
    OP_MUL     = 3'd0,
    OP_SCREEN  = 3'd1,
    OP_SUB     = 3'd2,
    OP_OVERLAY = 3'd3,
    OP_SCALE   = 3'd4,
    OP_PASS    = 3'd5
  } lane_op_t;

  // pick what one lane does for the current blend mode
  function automatic lane_op_t lane_op_for(logic [2:0] mode, logic [1:0] lane);
    lane_op_t op;
    case (mode)
      MODE_MULTIPLY:   op = OP_MUL;
      MODE_SCREEN:     op = OP_SCREEN;
      MODE_SUBTRACT:   op = OP_SUB;
      MODE_OVERLAY:    op = OP_OVERLAY;
      MODE_SCALE_RED:  op = (lane == LANE_RED) ? OP_SCALE : OP_PASS;
      MODE_SCALE_BLUE: op = (lane == LANE_BLUE) ? OP_SCALE : OP_PASS;
      default:         op = OP_PASS;
    endcase
    return op;
  endfunction

endpackage

// ===== hw/rtl/rlbu_lane.sv =====
`timescale 1ns / 1ps

module rlbu_lane import rlbu_pkg::*; (
  input  logic              clk,
  input  logic              load,
  input  lane_op_t          op,
  input  logic [CHAN_W-1:0] top_ch,
  input  logic [CHAN_W-1:0] bottom_ch,
  input  logic [CHAN_W-1:0] scale,
  output logic [CHAN_W-1:0] result
);

  logic                  inv_nxt;
  logic                  dbl_nxt;
  logic [CHAN_W-1:0]     opa;
  logic [CHAN_W-1:0]     opb;
  logic [2*CHAN_W-1:0]   prod_nxt;

  logic [2*CHAN_W-1:0]   prod_r;
  logic                  inv_r;
  logic                  dbl_r;
  lane_op_t              op_r;
  logic [CHAN_W-1:0]     top_r;
  logic [CHAN_W-1:0]     bottom_r;

  logic [2*CHAN_W+1:0]   biased;
  logic [4*CHAN_W+3:0]   recip;
  logic [CHAN_W:0]       quot;
  logic [CHAN_W-1:0]     quot_sat;

  // operand selection: screen and upper overlay work on inverted channels
  always_comb begin
    inv_nxt  = (op == OP_SCREEN) || ((op == OP_OVERLAY) && bottom_ch[CHAN_W-1]);
    dbl_nxt  = (op == OP_OVERLAY);
    opa      = inv_nxt ? ~top_ch : top_ch;
    opb      = (op == OP_SCALE) ? scale : (inv_nxt ? ~bottom_ch : bottom_ch);
    prod_nxt = {{CHAN_W{1'b0}}, opa} * {{CHAN_W{1'b0}}, opb};
  end

  // product register
  always_ff @(posedge clk) begin
    if (load) begin
      prod_r   <= prod_nxt;
      inv_r    <= inv_nxt;
      dbl_r    <= dbl_nxt;
      op_r     <= op;
      top_r    <= top_ch;
      bottom_r <= bottom_ch;
    end
  end

  // rounded divide by 255 through the reciprocal
  always_comb begin
    biased   = (dbl_r ? {1'b0, prod_r, 1'b0} : {2'b00, prod_r})
               + (2*CHAN_W+2)'(ROUND_BIAS);
    recip    = {{(2*CHAN_W+2){1'b0}}, biased} * (4*CHAN_W+4)'(DIV255_MUL);
    quot     = (CHAN_W+1)'(recip >> DIV255_SHIFT);
    quot_sat = quot[CHAN_W] ? {CHAN_W{1'b1}} : quot[CHAN_W-1:0];
  end

  // final per-channel result
  always_comb begin
    case (op_r)
      OP_MUL:     result = quot_sat;
      OP_SCREEN:  result = {CHAN_W{1'b1}} - quot_sat;
      OP_OVERLAY: result = inv_r ? ({CHAN_W{1'b1}} - quot_sat) : quot_sat;
      OP_SUB:     result = (bottom_r > top_r) ? (bottom_r - top_r) : '0;
      OP_SCALE:   result = (prod_r[2*CHAN_W-1:CHAN_W] != '0) ? {CHAN_W{1'b1}}
                                                              : prod_r[CHAN_W-1:0];
      default:    result = top_r;
    endcase
  end

endmodule

// ===== hw/rtl/rgb_layer_blend_unit_top.sv =====
`timescale 1ns / 1ps
// channel | direction | tdata fields (lowest bit up)
// in_*    | request in  | top_red, top_green, top_blue, bottom_red, bottom_green, bottom_blue
// out_*   | request out | out_red, out_green, out_blue
// cfg_*   | write only  | 0 blend_mode, 1 scale_factor
//
// one pixel pair per cycle while out_tready is high; an accepted pair passes through
// the lane product register, then the merged output register
// rst_n is synchronous active low; configuration registers reset to multiply mode, gain 1
// a stalled output holds one request in the output register and one in the
// product register; input stalls only when both are full and out_tready is low

module rgb_layer_blend_unit_top import rlbu_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // top_red, top_green, top_blue, bottom_red, bottom_green, bottom_blue
  input  logic [6*CHAN_W-1:0]     in_tdata,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // out_red, out_green, out_blue
  output logic [3*CHAN_W-1:0]     out_tdata,
  input  logic                    cfg_we,
  input  logic [CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

`include "rgb_layer_blend_unit_top_macros.svh"

  logic [2:0]            mode_r;
  logic [CHAN_W-1:0]     scale_r;
  logic                  s1_valid_r;
  logic                  s1_valid_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [3*CHAN_W-1:0]   out_data_r;
  logic                  out_load;
  logic [CHAN_W-1:0]     lane_res [NUM_LANES];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_MULTIPLY;
      scale_r <= CHAN_W'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_BLEND_MODE:   mode_r  <= cfg_wdata[2:0];
        REG_SCALE_FACTOR: scale_r <= cfg_wdata[CHAN_W-1:0];
        default:          ;
      endcase
    end
  end

  // pipeline flow control
  always_comb begin
    out_load      = !out_valid_r || out_tready;
    in_tready     = !s1_valid_r || out_load;
    s1_valid_nxt  = in_tready ? in_tvalid : s1_valid_r;
    out_valid_nxt = out_load ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // one lane per color channel
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    rlbu_lane u_lane (
      .clk       (clk),
      .load      (in_tready),
      .op        (lane_op_for(mode_r, 2'(g))),
      .top_ch    (in_tdata[g*CHAN_W +: CHAN_W]),
      .bottom_ch (in_tdata[(g+NUM_LANES)*CHAN_W +: CHAN_W]),
      .scale     (scale_r),
      .result    (lane_res[g])
    );
  end

  // merge lane results into the output register
  always_ff @(posedge clk) begin
    if (out_load && s1_valid_r) begin
      out_data_r <= {lane_res[2], lane_res[1], lane_res[0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  `RLBU_ASSERT_SAME(a_full_blocks, s1_valid_r && out_valid_r && !out_tready, !in_tready, "input taken while pipeline full")
  `RLBU_ASSERT_NEXT(a_accept_fills, in_tvalid && in_tready, s1_valid_r, "accepted request lost at product stage")
  `RLBU_ASSERT_NEXT(a_advance, s1_valid_r && out_load, out_valid_r, "request lost at output stage")
  `RLBU_ASSERT_NEXT(a_cfg_mode, cfg_we && (cfg_addr == REG_BLEND_MODE), mode_r == $past(cfg_wdata[2:0]), "blend mode write not taken")

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb import rlbu_pkg::*; ();

  // unused codes: spare register indexes and mode values that pass the top pixel
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 2'd3;
  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;

  localparam int NUM_PHASES      = 10;
  localparam int PHASE_PAIRS     = 104;
  localparam int HOLDOFF_CYCLES  = 300;
  localparam int WATCHDOG_CYCLES = 4000;
  localparam int DRAIN_CYCLES    = 8;

  // red in the lowest bits, as on the bus
  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } rgb_t;

  typedef struct packed {
    rgb_t bottom;
    rgb_t top;
  } pixel_pair_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [6*CHAN_W-1:0]   in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [3*CHAN_W-1:0]   out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  pixel_pair_t pending_pairs[$];
  rgb_t        expected_pixels[$];

  // predictor copy of the blend registers
  logic [2:0]        cur_mode = MODE_MULTIPLY;
  logic [CHAN_W-1:0] cur_gain = 8'd1;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int holdoff_left   = 0;
  int mismatches     = 0;
  int quiet_cycles   = 0;

  rgb_layer_blend_unit_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // append to the pending and expected queues
  function automatic void queue_pair(pixel_pair_t pr);
    pending_pairs.insert(pending_pairs.size(), pr);
  endfunction

  function automatic void queue_expected(rgb_t px);
    expected_pixels.insert(expected_pixels.size(), px);
  endfunction

  function automatic logic [CHAN_W-1:0] clamp_byte(int unsigned x);
    return (x > 255) ? 8'd255 : 8'(x);
  endfunction

  // one channel of the four per-lane blend modes
  function automatic logic [CHAN_W-1:0] blend_lane(logic [2:0] mode, logic [CHAN_W-1:0] t8,
                                                   logic [CHAN_W-1:0] b8);
    int unsigned t, b, it, ib;
    logic [CHAN_W-1:0] r;
    t  = t8;
    b  = b8;
    it = 255 - t;
    ib = 255 - b;
    case (mode)
      MODE_MULTIPLY: r = 8'((t * b + 127) / 255);
      MODE_SCREEN:   r = 8'(255 - (it * ib + 127) / 255);
      MODE_SUBTRACT: r = (b > t) ? 8'(b - t) : 8'd0;
      MODE_OVERLAY: begin
        if (b < 128) r = clamp_byte((2 * t * b + 127) / 255);
        else r = 8'(255 - clamp_byte((2 * it * ib + 127) / 255));
      end
      default: r = t8;
    endcase
    return r;
  endfunction

  // expected blended pixel under the current registers
  function automatic rgb_t blend_pixel(pixel_pair_t pr);
    rgb_t px;
    px = pr.top;
    case (cur_mode)
      MODE_MULTIPLY, MODE_SCREEN, MODE_SUBTRACT, MODE_OVERLAY: begin
        px.red   = blend_lane(cur_mode, pr.top.red, pr.bottom.red);
        px.green = blend_lane(cur_mode, pr.top.green, pr.bottom.green);
        px.blue  = blend_lane(cur_mode, pr.top.blue, pr.bottom.blue);
      end
      MODE_SCALE_RED:  px.red = clamp_byte(32'(pr.top.red) * 32'(cur_gain));
      MODE_SCALE_BLUE: px.blue = clamp_byte(32'(pr.top.blue) * 32'(cur_gain));
      default: px = pr.top;
    endcase
    return px;
  endfunction

  function automatic pixel_pair_t pair_of(logic [7:0] tr, logic [7:0] tg, logic [7:0] tb,
                                          logic [7:0] br, logic [7:0] bg, logic [7:0] bb);
    pixel_pair_t pr;
    pr.top    = '{blue: tb, green: tg, red: tr};
    pr.bottom = '{blue: bb, green: bg, red: br};
    return pr;
  endfunction

  // channel value leaning toward the edges and the overlay threshold
  function automatic logic [CHAN_W-1:0] rand_chan();
    logic [CHAN_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = 8'd0;
      1:       v = 8'd255;
      2:       v = 8'd127 + 8'($urandom_range(0, 1));
      default: v = 8'($urandom_range(0, 255));
    endcase
    return v;
  endfunction

  task automatic report_mismatch(string what, int want, int got);
    $display("mismatch %s: expected %0d got %0d", what, want, got);
    mismatches++;
  endtask

  // register write, predictor follows
  task automatic cfg_write(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BLEND_MODE) cur_mode = data[2:0];
    else if (idx == REG_SCALE_FACTOR) cur_gain = data;
  endtask

  // mode code with random bits above the register width
  task automatic set_mode(logic [2:0] mode);
    cfg_write(REG_BLEND_MODE, {5'($urandom), mode});
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_pairs.size() != 0 || in_tvalid || expected_pixels.size() != 0);
  endtask

  task automatic queue_random(int count);
    for (int i = 0; i < count; i++) begin
      queue_pair(pair_of(rand_chan(), rand_chan(), rand_chan(),
                         rand_chan(), rand_chan(), rand_chan()));
    end
  endtask

  // driver: offer pending pairs, predict each accepted request
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      if (in_tvalid && in_tready) queue_expected(blend_pixel(in_tdata));
      if (!in_tvalid || in_tready) begin
        if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_pairs.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: check results in order, drive back-pressure
  always @(posedge clk) begin : monitor_blk
    rgb_t want;
    rgb_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected pixel", 0, out_tdata);
        end else begin
          want = expected_pixels.pop_front();
          if (got.red !== want.red) report_mismatch("out_red", want.red, got.red);
          if (got.green !== want.green) report_mismatch("out_green", want.green, got.green);
          if (got.blue !== want.blue) report_mismatch("out_blue", want.blue, got.blue);
        end
      end
      if (holdoff_left != 0) begin
        holdoff_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on stretches with no request moving
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // stimulus and configuration sequence
  initial begin : stim_blk
    pixel_pair_t dir_px[3];
    logic [2:0]  phase_mode[NUM_PHASES];
    phase_mode = '{MODE_MULTIPLY, MODE_SCREEN, MODE_SUBTRACT, MODE_OVERLAY, MODE_SCALE_RED,
                   MODE_SCALE_BLUE, MODE_SCALE_RED, MODE_SCALE_BLUE, MODE_SPARE_A,
                   MODE_OVERLAY};
    // channel extremes, overlay threshold on both sides, subtract both ways
    dir_px[0] = pair_of(8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd0);
    dir_px[1] = pair_of(8'd255, 8'd0, 8'd128, 8'd0, 8'd255, 8'd127);
    dir_px[2] = pair_of(8'd128, 8'd127, 8'd1, 8'd128, 8'd128, 8'd254);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers first, then each per-lane mode
    for (int m = 0; m < 4; m++) begin
      if (m != 0) set_mode(3'(m));
      for (int i = 0; i < 3; i++) queue_pair(dir_px[i]);
      wait_drained();
    end

    // scale modes: reset gain, full gain, zero gain
    set_mode(MODE_SCALE_RED);
    queue_pair(dir_px[1]);
    queue_pair(dir_px[2]);
    wait_drained();
    cfg_write(REG_SCALE_FACTOR, 8'd255);
    queue_pair(dir_px[1]);
    wait_drained();
    set_mode(MODE_SCALE_BLUE);
    cfg_write(REG_SCALE_FACTOR, 8'd0);
    queue_pair(dir_px[0]);
    wait_drained();

    // writes to spare indexes must leave the registers alone
    cfg_write(REG_SPARE_A, 8'($urandom));
    cfg_write(REG_SPARE_B, 8'($urandom));
    queue_pair(dir_px[2]);
    wait_drained();

    // unused mode codes pass the top pixel
    set_mode(MODE_SPARE_A);
    queue_pair(dir_px[1]);
    wait_drained();
    set_mode(MODE_SPARE_B);
    queue_pair(dir_px[2]);
    wait_drained();

    // random phases over mode, gain and idling pattern
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_mode(phase_mode[p]);
      if (p == 4) cfg_write(REG_SCALE_FACTOR, 8'd0);
      else if (p == 5) cfg_write(REG_SCALE_FACTOR, 8'd255);
      else if (p == 6) cfg_write(REG_SCALE_FACTOR, 8'd1);
      else cfg_write(REG_SCALE_FACTOR, 8'($urandom_range(0, 255)));
      if (p == 8) cfg_write(REG_SPARE_B, 8'($urandom));
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      if (p == 2) begin
        // long receiver hold-off while the sender keeps offering
        queue_random(PHASE_PAIRS);
        @(negedge clk);
        holdoff_left = HOLDOFF_CYCLES;
      end else if (p == 5) begin
        // sender pauses mid-phase until everything has come back
        queue_random(PHASE_PAIRS / 2);
        wait_drained();
        queue_random(PHASE_PAIRS - PHASE_PAIRS / 2);
      end else begin
        queue_random(PHASE_PAIRS);
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
